FILE: rtl/cbsd_pkg.sv
// ----------------------------------------------------------------------------
// cbsd_pkg
// Shared types and constants for the chunked byte stream diff unit.
// ----------------------------------------------------------------------------
package cbsd_pkg;

  // field widths
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned CHUNK_BITS = 4;
  localparam int unsigned OUT_BITS   = 48;

  // default address width and reset chunk size (log2, 16 bytes)
  localparam int unsigned            ADDR_BITS_DEFAULT = 48;
  localparam logic [CHUNK_BITS-1:0]  CHUNK_LOG2_RESET  = 4'd4;

  // one byte pair word as it travels to the run tracker
  typedef struct packed {
    logic [BYTE_BITS-1:0] byte_a;
    logic [BYTE_BITS-1:0] byte_b;
    logic                 is_last;
  } cbsd_item_t;

endpackage

FILE: rtl/chunked_byte_stream_diff_unit.sv
// ----------------------------------------------------------------------------
// chunked_byte_stream_diff_unit
// Finds runs of differing aligned chunks between two byte streams.
// ----------------------------------------------------------------------------
// One byte pair word enters on the in_ channel per cycle while in_stall is
// low, starting at address zero; in_is_last marks the final pair and returns
// the block to its start state after any open run is reported. A partial
// final chunk is not judged. Each out_ word carries a run's chunk-aligned
// start address and its length in bytes. cfg_wr_en loads cfg_wr_data as log2
// of the chunk size (reset 4, 16 bytes); write it only while no word is in
// flight. An accepted word sits in the input register, the tracker judges it
// combinationally, and its result (if any) is loaded into the output
// register, which drives out_valid. Throughput is one word per cycle while
// the receiver does not stall, set by the combinational compare and run
// update in the tracker.
// When the receiver stalls with a result held, the input register fills and
// then in_stall is raised; no word is dropped. Reset is synchronous and
// active low, clears address, run state and both valid flags, and sets the
// chunk size to 16 bytes.
// ----------------------------------------------------------------------------
module chunked_byte_stream_diff_unit
  import cbsd_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_BITS-1:0]  in_byte_a,
  input  logic [BYTE_BITS-1:0]  in_byte_b,
  input  logic                  in_is_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_BITS-1:0]   out_run_start,
  output logic [OUT_BITS-1:0]   out_run_length,
  input  logic                  cfg_wr_en,
  input  logic [CHUNK_BITS-1:0] cfg_wr_data
);

  logic [CHUNK_BITS-1:0] chunk_log2_r;
  logic                  s1_valid_r;
  cbsd_item_t            s1_item_r;
  logic                  out_valid_r;
  logic [OUT_BITS-1:0]   out_run_start_r;
  logic [OUT_BITS-1:0]   out_run_length_r;

  logic                  out_free;
  logic                  s1_go;
  logic                  in_take;
  logic                  emit;
  logic [ADDR_BITS-1:0]  emit_start;
  logic [ADDR_BITS-1:0]  emit_length;
  logic [63:0]           start_wide;
  logic [63:0]           length_wide;

  // handshake
  assign out_free = ~out_valid_r | ~out_stall;
  assign s1_go    = s1_valid_r & out_free;
  assign in_stall = s1_valid_r & ~out_free;
  assign in_take  = in_valid & ~in_stall;

  // chunk size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_log2_r <= CHUNK_LOG2_RESET;
    end else if (cfg_wr_en) begin
      chunk_log2_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.byte_a  <= in_byte_a;
      s1_item_r.byte_b  <= in_byte_b;
      s1_item_r.is_last <= in_is_last;
    end
  end

  // run tracking
  cbsd_run_tracker #(
    .ADDR_BITS(ADDR_BITS)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .item       (s1_item_r),
    .chunk_log2 (chunk_log2_r),
    .emit       (emit),
    .emit_start (emit_start),
    .emit_length(emit_length)
  );

  // fit the run to the output width
  assign start_wide  = 64'(emit_start);
  assign length_wide = 64'(emit_length);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_run_start_r  <= start_wide[OUT_BITS-1:0];
      out_run_length_r <= length_wide[OUT_BITS-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_run_start  = out_run_start_r;
  assign out_run_length = out_run_length_r;

endmodule

FILE: rtl/cbsd_run_tracker.sv
// ----------------------------------------------------------------------------
// cbsd_run_tracker
// Holds the byte address, the chunk difference flag and the open run; judges
// each chunk at its last byte and reports a run when it closes or is flushed.
// ----------------------------------------------------------------------------
module cbsd_run_tracker
  import cbsd_pkg::*;
#(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  cbsd_item_t            item,
  input  logic [CHUNK_BITS-1:0] chunk_log2,
  output logic                  emit,
  output logic [ADDR_BITS-1:0]  emit_start,
  output logic [ADDR_BITS-1:0]  emit_length
);

  logic [ADDR_BITS-1:0] byte_address_r, byte_address_nxt;
  logic                 chunk_differs_r, chunk_differs_nxt;
  logic                 run_open_r, run_open_nxt;
  logic [ADDR_BITS-1:0] open_start_r, open_start_nxt;
  logic [ADDR_BITS-1:0] open_length_r, open_length_nxt;

  logic [ADDR_BITS-1:0] size;
  logic [ADDR_BITS-1:0] offs;
  logic                 differs;
  logic                 at_end;
  logic                 run_open_upd;
  logic [ADDR_BITS-1:0] start_upd;
  logic [ADDR_BITS-1:0] length_upd;
  logic                 emit_close;
  logic                 emit_flush;

  // chunk geometry and end-of-chunk detect
  assign size    = ADDR_BITS'(1) << chunk_log2;
  assign offs    = size - ADDR_BITS'(1);
  assign differs = chunk_differs_r | (item.byte_a != item.byte_b);
  assign at_end  = ((byte_address_r & offs) == offs);

  // run update at a chunk boundary
  always_comb begin
    run_open_upd = run_open_r;
    start_upd    = open_start_r;
    length_upd   = open_length_r;
    if (at_end) begin
      if (!differs) begin
        run_open_upd = 1'b0;
      end else if (!run_open_r) begin
        run_open_upd = 1'b1;
        start_upd    = byte_address_r & ~offs;
        length_upd   = size;
      end else begin
        length_upd   = open_length_r + size;
      end
    end
  end

  // an equal chunk closes a run; the last word flushes one still open
  assign emit_close  = at_end & ~differs & run_open_r;
  assign emit_flush  = item.is_last & run_open_upd;
  assign emit        = step & (emit_close | emit_flush);
  assign emit_start  = start_upd;
  assign emit_length = length_upd;

  // next state, cleared after the last word
  always_comb begin
    byte_address_nxt  = byte_address_r;
    chunk_differs_nxt = chunk_differs_r;
    run_open_nxt      = run_open_r;
    open_start_nxt    = open_start_r;
    open_length_nxt   = open_length_r;
    if (step) begin
      if (item.is_last) begin
        byte_address_nxt  = '0;
        chunk_differs_nxt = 1'b0;
        run_open_nxt      = 1'b0;
        open_start_nxt    = '0;
        open_length_nxt   = '0;
      end else begin
        byte_address_nxt  = byte_address_r + ADDR_BITS'(1);
        chunk_differs_nxt = at_end ? 1'b0 : differs;
        run_open_nxt      = run_open_upd;
        open_start_nxt    = start_upd;
        open_length_nxt   = length_upd;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_address_r  <= '0;
      chunk_differs_r <= 1'b0;
      run_open_r      <= 1'b0;
    end else begin
      byte_address_r  <= byte_address_nxt;
      chunk_differs_r <= chunk_differs_nxt;
      run_open_r      <= run_open_nxt;
    end
  end

  // run payload, only read while a run is open
  always_ff @(posedge clk) begin
    open_start_r  <= open_start_nxt;
    open_length_r <= open_length_nxt;
  end

endmodule
